>>> hw/rtl/mqdr_pkg.sv
package mqdr_pkg;

  // request operation codes
  localparam int OP_W = 2;
  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_PUSH    = 2'd0;
  localparam op_t OP_POP     = 2'd1;
  localparam op_t OP_PENDING = 2'd2;

  // destination number on the request channel
  localparam int TQ_W = 8;

  // configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_QUEUE_LENGTH = 2'd0;
  localparam cfg_idx_t REG_QUEUE_COUNT  = 2'd1;

  localparam int QLEN_W = 5;
  localparam int QCNT_W = 4;
  localparam logic [QLEN_W-1:0] QLEN_RESET = 5'd16;
  localparam logic [QCNT_W-1:0] QCNT_RESET = 4'd8;

endpackage

>>> hw/rtl/mqdr_ram.sv
module mqdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/multi_queue_descriptor_ring.sv
// Multi-queue descriptor ring.
// One circular FIFO of descriptor words per destination queue, all held in
// one shared descriptor RAM; per-queue head/tail/count live in a small
// pointer RAM. Each request is a push, pop or pending-count query.
// Request channel: a request is taken at a rising edge with start high and
// busy low. Operation, target_queue and descriptor_in are sampled there.
// Result channel: done is high for exactly one cycle with status,
// descriptor_out and pending_count; the receiver cannot stall it.
// Sequence: push, query and error requests pass the pointer read (S_READ),
// then the update into the result register (S_EXEC); a good pop also reads
// the descriptor RAM and moves its word to the result in S_POP. busy drops
// in the cycle done shows, so a new request can go in under a result, but
// none is taken while one is in flight, since each request runs a
// read-modify-write of the pointer RAM.
// Config channel: cfg_ready is always high; writes take effect at the edge
// that takes them and are meant only while the block is idle.
// Reset: synchronous rst puts the controller idle, loads the register
// defaults and clears the pointer RAM valid bits, so every queue reads empty
// at once. The descriptor RAM is not cleared.
module multi_queue_descriptor_ring #(
  parameter int MAX_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int DESC_WIDTH  = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         start,
  output logic                         busy,
  input  mqdr_pkg::op_t                operation,
  input  logic [mqdr_pkg::TQ_W-1:0]    target_queue,
  input  logic [DESC_WIDTH-1:0]        descriptor_in,
  // result channel
  output logic                         done,
  output logic                         status,
  output logic [DESC_WIDTH-1:0]        descriptor_out,
  output logic [$clog2(QUEUE_DEPTH + 1)-1:0] pending_count,
  // configuration channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  mqdr_pkg::cfg_idx_t           cfg_index,
  input  logic [mqdr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mqdr_pkg::*;

  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int QW      = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int L_W     = (CNT_W > QLEN_W) ? CNT_W : QLEN_W;
  localparam int PE_W    = 2 * PTR_W + CNT_W;
  localparam int DDEPTH  = MAX_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W  = $clog2(DDEPTH);

  // controller states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_POP  = 2'd3;

  logic [1:0] state;

  // configuration registers
  logic [QLEN_W-1:0] queue_length;
  logic [QCNT_W-1:0] queue_count_in_use;

  // latched request
  op_t                 req_op;
  logic [QW-1:0]       req_q;
  logic                req_ok;
  logic [DESC_WIDTH-1:0] req_desc;

  // pointer RAM bookkeeping
  logic [MAX_QUEUES-1:0] ptr_valid;
  logic                  rd_valid;
  logic [PE_W-1:0]       ptr_rdata;
  logic [PE_W-1:0]       ptr_cur;
  logic [PE_W-1:0]       ptr_wdata;
  logic                  ptr_we;
  logic                  ptr_re;

  logic [PTR_W-1:0] head, tail, head_next, tail_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [L_W-1:0]   eff_len;
  logic             push_ok, pop_ok, pend_ok;

  // descriptor RAM
  logic [ADDR_W-1:0]     desc_addr;
  logic [DESC_WIDTH-1:0] desc_rdata;
  logic                  desc_we, desc_re;

  logic accept;
  logic dest_ok;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] idx,
                                               input logic [L_W-1:0] len);
    logic [L_W-1:0] nxt;
    nxt = L_W'(idx) + L_W'(1);
    return (nxt >= len) ? '0 : nxt[PTR_W-1:0];
  endfunction

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // destination check at accept: below the enabled count and the built count
  assign dest_ok = (TQ_W'(queue_count_in_use) > target_queue) &&
                   (32'(target_queue) < MAX_QUEUES);

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_length       <= QLEN_RESET;
      queue_count_in_use <= QCNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_QUEUE_LENGTH: queue_length       <= cfg_data[QLEN_W-1:0];
        REG_QUEUE_COUNT:  queue_count_in_use <= cfg_data[QCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // length clamp: zero acts as one, beyond the built depth acts as the depth
  always_comb begin
    if (queue_length == '0) begin
      eff_len = L_W'(1);
    end else if (L_W'(queue_length) > L_W'(QUEUE_DEPTH)) begin
      eff_len = L_W'(QUEUE_DEPTH);
    end else begin
      eff_len = L_W'(queue_length);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op   <= operation;
      req_q    <= dest_ok ? target_queue[QW-1:0] : '0;
      req_desc <= descriptor_in;
    end
  end

  // never-written pointer entries read as zero
  assign ptr_cur = rd_valid ? ptr_rdata : '0;
  assign head    = ptr_cur[PE_W-1 -: PTR_W];
  assign tail    = ptr_cur[CNT_W +: PTR_W];
  assign cnt     = ptr_cur[CNT_W-1:0];

  assign push_ok = req_ok && (req_op == OP_PUSH) && (L_W'(cnt) < eff_len);
  assign pop_ok  = req_ok && (req_op == OP_POP) && (cnt != '0);
  assign pend_ok = req_ok && (req_op == OP_PENDING);

  always_comb begin
    head_next = head;
    tail_next = tail;
    cnt_next  = cnt;
    if (push_ok) begin
      tail_next = advance(tail, eff_len);
      cnt_next  = cnt + CNT_W'(1);
    end else if (pop_ok) begin
      head_next = advance(head, eff_len);
      cnt_next  = cnt - CNT_W'(1);
    end
  end

  assign ptr_re    = (state == S_READ);
  assign ptr_we    = (state == S_EXEC) && (push_ok || pop_ok);
  assign ptr_wdata = {head_next, tail_next, cnt_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_valid <= '0;
    end else if (ptr_we) begin
      ptr_valid[req_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ptr_re) begin
      rd_valid <= ptr_valid[req_q];
    end
  end

  mqdr_ram #(
    .WIDTH(PE_W),
    .DEPTH(MAX_QUEUES)
  ) u_ptr_ram (
    .clk  (clk),
    .we   (ptr_we),
    .waddr(req_q),
    .wdata(ptr_wdata),
    .re   (ptr_re),
    .raddr(req_q),
    .rdata(ptr_rdata)
  );

  // slot address: queue base plus tail (push) or head (pop)
  assign desc_addr = ADDR_W'(req_q) * ADDR_W'(QUEUE_DEPTH) +
                     ADDR_W'(push_ok ? tail : head);
  assign desc_we   = (state == S_EXEC) && push_ok;
  assign desc_re   = (state == S_EXEC) && pop_ok;

  mqdr_ram #(
    .WIDTH(DESC_WIDTH),
    .DEPTH(DDEPTH)
  ) u_desc_ram (
    .clk  (clk),
    .we   (desc_we),
    .waddr(desc_addr),
    .wdata(req_desc),
    .re   (desc_re),
    .raddr(desc_addr),
    .rdata(desc_rdata)
  );

  // controller and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      req_ok <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_ok <= dest_ok;
            state  <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (pop_ok) begin
            state <= S_POP;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_POP: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_EXEC: begin
        status         <= !(push_ok || pop_ok || pend_ok);
        descriptor_out <= '0;
        pending_count  <= pend_ok ? cnt : '0;
      end
      S_POP: begin
        status         <= 1'b0;
        descriptor_out <= desc_rdata;
        pending_count  <= '0;
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/mqdr_check.sv
module mqdr_check #(
  parameter int DESC_WIDTH = 64,
  parameter int CNT_W      = 5
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input logic                  status,
  input logic [DESC_WIDTH-1:0] descriptor_out,
  input logic [CNT_W-1:0]      pending_count
);

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("busy or done after reset");

  // a taken request keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // a result only follows work in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in flight");

  // single-cycle result strobe
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // an error result carries zero payload
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (descriptor_out == '0 && pending_count == '0))
    else $error("error result with nonzero payload");

endmodule

bind multi_queue_descriptor_ring mqdr_check #(
  .DESC_WIDTH(DESC_WIDTH),
  .CNT_W     (CNT_W)
) u_mqdr_check (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .descriptor_out(descriptor_out),
  .pending_count (pending_count)
);

>>> test/mqdr_checker.sv
module mqdr_checker
  import mqdr_pkg::*;
#(
  parameter int MAX_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int DESC_WIDTH  = 64,
  parameter int CNT_W       = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  op_t                   operation,
  input  logic [TQ_W-1:0]       target_queue,
  input  logic [DESC_WIDTH-1:0] descriptor_in,
  input  logic                  done,
  input  logic                  status,
  input  logic [DESC_WIDTH-1:0] descriptor_out,
  input  logic [CNT_W-1:0]      pending_count,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    results_due
);

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int SLOTS  = MAX_QUEUES * QUEUE_DEPTH;
  localparam int QI_W   = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef struct packed {
    logic                  status;
    logic [DESC_WIDTH-1:0] desc;
    logic [CNT_W-1:0]      pend;
  } ring_result_t;

  // shadow ring state
  logic [IDX_W-1:0]      ring_head [MAX_QUEUES];
  logic [IDX_W-1:0]      ring_tail [MAX_QUEUES];
  logic [CNT_W-1:0]      ring_fill [MAX_QUEUES];
  logic [DESC_WIDTH-1:0] ring_mem  [SLOTS];
  logic [QLEN_W-1:0]     cfg_qlen;
  logic [QCNT_W-1:0]     cfg_qcnt;

  ring_result_t due_results[$];

  function automatic int active_length();
    if (cfg_qlen == 0) return 1;
    if (cfg_qlen > QUEUE_DEPTH) return QUEUE_DEPTH;
    return int'(cfg_qlen);
  endfunction

  function automatic logic [IDX_W-1:0] step_index(logic [IDX_W-1:0] idx, int len);
    int nxt;
    nxt = int'(idx) + 1;
    return (nxt >= len) ? '0 : nxt[IDX_W-1:0];
  endfunction

  task automatic model_ring_request(input op_t op, input logic [TQ_W-1:0] q,
                                    input logic [DESC_WIDTH-1:0] d,
                                    output ring_result_t r);
    int len;
    int nq;
    int base;
    logic [QI_W-1:0]   qi;
    logic [SLOT_W-1:0] slot;
    len = active_length();
    nq  = (cfg_qcnt > MAX_QUEUES) ? MAX_QUEUES : int'(cfg_qcnt);
    r = '0;
    r.status = 1'b1;
    if (int'(q) < nq && int'(q) < MAX_QUEUES) begin
      qi   = q[QI_W-1:0];
      base = int'(q) * QUEUE_DEPTH;
      case (op)
        OP_PUSH: begin
          if (ring_fill[qi] < len) begin
            slot = SLOT_W'(base + int'(ring_tail[qi]));
            ring_mem[slot] = d;
            ring_tail[qi] = step_index(ring_tail[qi], len);
            ring_fill[qi] = ring_fill[qi] + 1'b1;
            r.status = 1'b0;
          end
        end
        OP_POP: begin
          if (ring_fill[qi] != 0) begin
            slot = SLOT_W'(base + int'(ring_head[qi]));
            r.desc = ring_mem[slot];
            ring_head[qi] = step_index(ring_head[qi], len);
            ring_fill[qi] = ring_fill[qi] - 1'b1;
            r.status = 1'b0;
          end
        end
        OP_PENDING: begin
          r.pend   = ring_fill[qi];
          r.status = 1'b0;
        end
        default: ;
      endcase
    end
  endtask

  always @(posedge clk) begin : watch
    ring_result_t seen;
    ring_result_t want;
    if (rst) begin
      cfg_qlen = QLEN_RESET;
      cfg_qcnt = QCNT_RESET;
      for (int i = 0; i < MAX_QUEUES; i++) begin
        ring_head[i] = '0;
        ring_tail[i] = '0;
        ring_fill[i] = '0;
      end
      due_results.delete();
    end else begin
      // retire the oldest request first: a new one may go in under a result
      if (done) begin
        seen = {status, descriptor_out, pending_count};
        if (due_results.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with no request waiting: status %0b desc %h pend %0d",
                     $realtime, status, descriptor_out, pending_count);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (seen.status !== want.status || seen.desc !== want.desc ||
              seen.pend !== want.pend) begin
            if (fail_count < 10)
              $display("%0t: mismatch exp/act status %0b/%0b desc %h/%h pend %0d/%0d",
                       $realtime, want.status, seen.status, want.desc, seen.desc,
                       want.pend, seen.pend);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        model_ring_request(operation, target_queue, descriptor_in, want);
        due_results.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_QUEUE_LENGTH: cfg_qlen = cfg_data[QLEN_W-1:0];
          REG_QUEUE_COUNT:  cfg_qcnt = cfg_data[QCNT_W-1:0];
          default: ;
        endcase
      end
    end
    results_due = due_results.size();
  end

endmodule

>>> test/tb_top.sv
module tb_top;
  import mqdr_pkg::*;

  localparam int MAX_QUEUES    = 8;
  localparam int QUEUE_DEPTH   = 16;
  localparam int DESC_WIDTH    = 64;
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int RANDOM_ITEMS  = 1650;
  // worst case is ~1950 requests, each with the longest gap; keep a wide margin
  localparam int CYCLE_LIMIT   = 400000;
  // settle time after every result is back, before a register write
  localparam int SETTLE_CYCLES = 6;
  // operation code with no meaning, answered with an error
  localparam op_t OP_UNKNOWN   = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  op_t                   operation;
  logic [TQ_W-1:0]       target_queue;
  logic [DESC_WIDTH-1:0] descriptor_in;
  logic                  done;
  logic                  status;
  logic [DESC_WIDTH-1:0] descriptor_out;
  logic [CNT_W-1:0]      pending_count;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int results_due;
  int cycle_count = 0;

  // stimulus side only tracks the queue count register, to aim requests at
  // enabled queues most of the time
  logic [QCNT_W-1:0] qcnt_shadow = QCNT_RESET;
  bit                gaps_on     = 1'b1;

  multi_queue_descriptor_ring #(
    .MAX_QUEUES (MAX_QUEUES),
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .DESC_WIDTH (DESC_WIDTH)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .target_queue  (target_queue),
    .descriptor_in (descriptor_in),
    .done          (done),
    .status        (status),
    .descriptor_out(descriptor_out),
    .pending_count (pending_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  mqdr_checker #(
    .MAX_QUEUES (MAX_QUEUES),
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .DESC_WIDTH (DESC_WIDTH),
    .CNT_W      (CNT_W)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .target_queue  (target_queue),
    .descriptor_in (descriptor_in),
    .done          (done),
    .status        (status),
    .descriptor_out(descriptor_out),
    .pending_count (pending_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .results_due   (results_due)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DESC_WIDTH-1:0] rand_desc();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic int enabled_queues();
    return (qcnt_shadow > MAX_QUEUES) ? MAX_QUEUES : int'(qcnt_shadow);
  endfunction

  // length mix: mostly legal, with the clamped values 0 and above the depth
  function automatic logic [CFG_DATA_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 16) return 1;
    if (r < 28) return 16;
    if (r < 40) return CFG_DATA_W'($urandom_range(17, 31));
    return CFG_DATA_W'($urandom_range(2, 15));
  endfunction

  // count mix: values above 15 only keep their low 4 bits in the register
  function automatic logic [CFG_DATA_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 35) return 8;
    if (r < 45) return CFG_DATA_W'($urandom_range(9, 31));
    if (r < 60) return 1;
    return CFG_DATA_W'($urandom_range(2, 7));
  endfunction

  task automatic pause(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // one request: hold it until the block takes it, then maybe idle
  task automatic issue(input op_t op, input logic [TQ_W-1:0] q,
                       input logic [DESC_WIDTH-1:0] d);
    start         <= 1'b1;
    operation     <= op;
    target_queue  <= q;
    descriptor_in <= d;
    do @(posedge clk); while (busy);
    @(negedge clk);
    pause(gaps_on ? gap_len() : 0);
  endtask

  // block idle: every result back, then a settle wait
  task automatic quiesce();
    start <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    if (idx == REG_QUEUE_COUNT) qcnt_shadow = val[QCNT_W-1:0];
  endtask

  task automatic random_request(input int push_pct);
    int    r;
    int    nq;
    op_t   op;
    logic [TQ_W-1:0] q;
    r  = $urandom_range(0, 99);
    nq = enabled_queues();
    if (r < 3) op = OP_UNKNOWN;
    else if (r < 13) op = OP_PENDING;
    else if ($urandom_range(0, 99) < push_pct) op = OP_PUSH;
    else op = OP_POP;
    r = $urandom_range(0, 99);
    if (nq > 0 && r < 85) q = TQ_W'($urandom_range(0, nq - 1));
    else q = TQ_W'($urandom_range(0, 255));
    issue(op, q, rand_desc());
  endtask

  initial begin : stimulus
    int sent;
    int phase_len;
    int push_pct;
    start         <= 1'b0;
    operation     <= OP_PUSH;
    target_queue  <= '0;
    descriptor_in <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_QUEUE_LENGTH;
    cfg_data      <= '0;
    rst           <= 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Warm-up: fill every queue to the full depth (one extra push hits the
    // full error), then drain it (one extra pop hits the empty error). After
    // this every descriptor slot holds a written word, so later length
    // changes with data queued never read a slot that was never written.
    for (int q = 0; q < MAX_QUEUES; q++)
      for (int i = 0; i <= QUEUE_DEPTH; i++) issue(OP_PUSH, TQ_W'(q), rand_desc());
    for (int q = 0; q < MAX_QUEUES; q++)
      for (int i = 0; i <= QUEUE_DEPTH; i++) issue(OP_POP, TQ_W'(q), rand_desc());

    // Directed: field extremes, every operation, bad destinations
    issue(OP_PENDING, 0, '0);
    issue(OP_PUSH, 0, '0);
    issue(OP_PUSH, 0, '1);
    issue(OP_PUSH, 7, 64'hA5A5_5A5A_F00F_0FF0);
    issue(OP_PENDING, 0, '1);
    issue(OP_PUSH, 8, '1);          // first disabled queue
    issue(OP_POP, 255, '0);
    issue(OP_PENDING, 255, '0);     // bad destination reads 0 pending
    issue(OP_UNKNOWN, 0, '1);       // unknown operation
    issue(OP_POP, 0, '0);
    issue(OP_POP, 0, '0);
    issue(OP_POP, 0, '0);           // empty
    issue(OP_POP, 7, '0);

    // length 0 behaves as a single slot
    quiesce();
    write_reg(REG_QUEUE_LENGTH, 5'd0);
    issue(OP_PUSH, 1, 64'h0123_4567_89AB_CDEF);
    issue(OP_PUSH, 1, '1);          // full at one entry
    issue(OP_PENDING, 1, '0);
    issue(OP_POP, 1, '0);

    // length above the depth clamps; count 0 disables every queue
    quiesce();
    write_reg(REG_QUEUE_LENGTH, 5'd31);
    write_reg(REG_QUEUE_COUNT, 5'd0);
    issue(OP_PUSH, 0, '1);
    issue(OP_PENDING, 0, '0);
    // count above the queue limit clamps to all queues
    quiesce();
    write_reg(REG_QUEUE_COUNT, 5'd15);
    issue(OP_PUSH, 7, 64'h8000_0000_0000_0001);
    issue(OP_POP, 7, '0);

    // shrink the length while a queue holds data
    quiesce();
    write_reg(REG_QUEUE_LENGTH, 5'd4);
    issue(OP_PUSH, 2, rand_desc());
    issue(OP_PUSH, 2, rand_desc());
    issue(OP_PUSH, 2, rand_desc());
    quiesce();
    write_reg(REG_QUEUE_LENGTH, 5'd2);
    issue(OP_PUSH, 2, rand_desc()); // count above new length: full
    issue(OP_PENDING, 2, '0);
    repeat (4) issue(OP_POP, 2, '0);

    // single enabled queue
    quiesce();
    write_reg(REG_QUEUE_COUNT, 5'd1);
    write_reg(REG_QUEUE_LENGTH, 5'd16);
    issue(OP_PUSH, 1, '1);
    issue(OP_PENDING, 0, '0);

    // Random phases: each picks a setting, a push/pop mix and a gap mode.
    // Push-heavy phases drive queues to full, pop-heavy ones drain them.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiesce();
      if ($urandom_range(0, 2) != 0) write_reg(REG_QUEUE_LENGTH, pick_length());
      if ($urandom_range(0, 2) != 0) write_reg(REG_QUEUE_COUNT, pick_count());
      gaps_on   = ($urandom_range(0, 3) != 0);
      push_pct  = $urandom_range(15, 85);
      phase_len = $urandom_range(40, 160);
      for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
        random_request(push_pct);
        sent++;
      end
    end
    gaps_on = 1'b1;

    // drain, then a short tail to catch stray results
    start <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/mqdr_pkg.sv
hw/rtl/mqdr_ram.sv
hw/rtl/multi_queue_descriptor_ring.sv
hw/rtl/mqdr_check.sv
test/mqdr_checker.sv
test/tb_top.sv
